FILE: rtl/core/adfd_pkg.sv
// Shared constants, codes and types of the packed 14-bit sample frame deframer.
package adfd_pkg;

    localparam int WORD_W       = 32;
    localparam int FRAME_WORDS  = 117;
    localparam int SPB          = 128;   // samples per block
    localparam int SAMPLE_BITS  = 14;
    localparam int BLOCK_WORDS  = (SPB * SAMPLE_BITS + WORD_W - 1) / WORD_W;
    localparam int DATA_START   = 4;
    localparam int DATA_END     = DATA_START + 2 * BLOCK_WORDS;
    localparam int MAX_OUT      = 3;

    localparam int POS_W   = $clog2(FRAME_WORDS);
    localparam int IDX_W   = $clog2(SPB + 1);
    localparam int CHAN_W  = 8;
    localparam int TICK_W  = 16;
    localparam int TS_W    = 64;
    localparam int SLOT_W  = 3;
    localparam int RES_W   = SAMPLE_BITS - 1 + WORD_W;
    localparam int FILL_W  = $clog2(RES_W + 1);
    localparam int CNT_W   = $clog2(MAX_OUT + 1);
    localparam int OFF_W   = $clog2(2 * BLOCK_WORDS);

    localparam int SLOT_LSB  = 12;
    localparam int FIBER_BIT = 15;
    localparam int TS_LOW    = 2;
    localparam int TS_HIGH   = 3;

    localparam logic [TICK_W-1:0] FPR_RESET = 16'd2000;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SLOT  = 2'd1,
        ST_FIBER = 2'd2
    } t_status;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_HDR    = 1'b1
    } t_kind;

    // one queued word: a header word or a sample-block data word
    typedef struct packed {
        t_kind               kind;
        logic                first;    // first word of a block
        logic                blk;
        logic [WORD_W-1:0]   word;
        logic [WORD_W-1:0]   ts_low;
        logic [TICK_W-1:0]   tick;
        logic [SLOT_W-1:0]   slot;
        logic                fiber;
        t_status             status;
    } t_q_entry;

    typedef struct packed {
        t_kind                  kind;
        logic [CHAN_W-1:0]      channel;
        logic [SAMPLE_BITS-1:0] sample;
        logic [TICK_W-1:0]      tick;
        logic [TS_W-1:0]        timestamp;
        logic [SLOT_W-1:0]      slot;
        logic                   fiber;
        t_status                status;
        logic                   last;
    } t_result;

endpackage

FILE: rtl/core/adfd_ifs.sv
// Valid/ready channel interfaces of the deframer: input words and result words.
interface adfd_in_if;
    logic                        valid;
    logic                        ready;
    logic [adfd_pkg::WORD_W-1:0] frame_word;

    modport source (output valid, output frame_word, input ready);
    modport sink   (input valid, input frame_word, output ready);
endinterface

interface adfd_out_if;
    logic                             valid;
    logic                             ready;
    logic                             kind;
    logic [adfd_pkg::CHAN_W-1:0]      channel;
    logic [adfd_pkg::SAMPLE_BITS-1:0] sample;
    logic [adfd_pkg::TICK_W-1:0]      tick;
    logic [adfd_pkg::TS_W-1:0]        timestamp;
    logic [adfd_pkg::SLOT_W-1:0]      slot;
    logic                             fiber;
    logic [1:0]                       status;
    logic                             last;

    modport source (output valid, output kind, output channel, output sample,
                    output tick, output timestamp, output slot, output fiber,
                    output status, output last, input ready);
    modport sink   (input valid, input kind, input channel, input sample,
                    input tick, input timestamp, input slot, input fiber,
                    input status, input last, output ready);
endinterface

FILE: rtl/core/adfd_front.sv
// Front end: tracks frame position, slot/fiber checks and tick, queues work words.
module adfd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [adfd_pkg::WORD_W-1:0]   i_word,
    output logic                          o_ready,
    input  logic [adfd_pkg::TICK_W-1:0]   i_fpr,
    input  logic                          i_q_full,
    output logic                          o_push,
    output adfd_pkg::t_q_entry            o_entry
);

    logic [adfd_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [adfd_pkg::TICK_W-1:0] r_tick, n_tick;
    logic [adfd_pkg::SLOT_W-1:0] r_lat_slot, n_lat_slot;
    logic                        r_lat_fiber, n_lat_fiber;
    logic [adfd_pkg::SLOT_W-1:0] r_fslot, n_fslot;
    logic                        r_ffiber, n_ffiber;
    adfd_pkg::t_status           r_fstatus, n_fstatus;
    logic [adfd_pkg::WORD_W-1:0] r_ts_low, n_ts_low;

    logic                        acc;
    logic [adfd_pkg::POS_W-1:0]  off_full;
    logic [adfd_pkg::OFF_W-1:0]  off;
    logic                        in_data;
    logic [adfd_pkg::TICK_W:0]   tick_inc;

    assign o_ready  = !i_q_full;
    assign acc      = i_valid && !i_q_full;
    assign off_full = r_pos - adfd_pkg::POS_W'(adfd_pkg::DATA_START);
    assign off      = off_full[adfd_pkg::OFF_W-1:0];
    assign in_data  = (r_pos >= adfd_pkg::POS_W'(adfd_pkg::DATA_START))
                   && (r_pos < adfd_pkg::POS_W'(adfd_pkg::DATA_END));
    assign tick_inc = {1'b0, r_tick} + 1'b1;

    always_comb begin
        n_pos       = r_pos;
        n_tick      = r_tick;
        n_lat_slot  = r_lat_slot;
        n_lat_fiber = r_lat_fiber;
        n_fslot     = r_fslot;
        n_ffiber    = r_ffiber;
        n_fstatus   = r_fstatus;
        n_ts_low    = r_ts_low;
        o_push      = 1'b0;

        o_entry.kind   = adfd_pkg::KIND_SAMPLE;
        o_entry.first  = (off == '0)
                      || (off == adfd_pkg::OFF_W'(adfd_pkg::BLOCK_WORDS));
        o_entry.blk    = (off >= adfd_pkg::OFF_W'(adfd_pkg::BLOCK_WORDS));
        o_entry.word   = i_word;
        o_entry.ts_low = r_ts_low;
        o_entry.tick   = r_tick;
        o_entry.slot   = r_fslot;
        o_entry.fiber  = r_ffiber;
        o_entry.status = r_fstatus;

        if (acc) begin
            if (r_pos == '0) begin
                n_fslot  = i_word[adfd_pkg::SLOT_LSB +: adfd_pkg::SLOT_W];
                n_ffiber = i_word[adfd_pkg::FIBER_BIT];
                if (r_tick == '0) begin
                    n_lat_slot  = n_fslot;
                    n_lat_fiber = n_ffiber;
                    n_fstatus   = adfd_pkg::ST_OK;
                end else if (n_fslot != r_lat_slot) begin
                    n_fstatus = adfd_pkg::ST_SLOT;
                end else if (n_ffiber != r_lat_fiber) begin
                    n_fstatus = adfd_pkg::ST_FIBER;
                end else begin
                    n_fstatus = adfd_pkg::ST_OK;
                end
            end else if (r_pos == adfd_pkg::POS_W'(adfd_pkg::TS_LOW)) begin
                n_ts_low = i_word;
            end else if (r_pos == adfd_pkg::POS_W'(adfd_pkg::TS_HIGH)) begin
                o_push       = 1'b1;
                o_entry.kind = adfd_pkg::KIND_HDR;
            end else if (in_data) begin
                o_push = 1'b1;
            end

            if (r_pos == adfd_pkg::POS_W'(adfd_pkg::FRAME_WORDS - 1)) begin
                n_pos = '0;
                // a zero setting acts as one frame per readout
                if (tick_inc >= {1'b0, i_fpr}) begin
                    n_tick = '0;
                end else begin
                    n_tick = tick_inc[adfd_pkg::TICK_W-1:0];
                end
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_tick      <= '0;
            r_lat_slot  <= '0;
            r_lat_fiber <= 1'b0;
            r_fslot     <= '0;
            r_ffiber    <= 1'b0;
            r_fstatus   <= adfd_pkg::ST_OK;
            r_ts_low    <= '0;
        end else begin
            r_pos       <= n_pos;
            r_tick      <= n_tick;
            r_lat_slot  <= n_lat_slot;
            r_lat_fiber <= n_lat_fiber;
            r_fslot     <= n_fslot;
            r_ffiber    <= n_ffiber;
            r_fstatus   <= n_fstatus;
            r_ts_low    <= n_ts_low;
        end
    end

endmodule

FILE: rtl/core/adfd_fifo.sv
// Short work queue between front end and unpacker.
module adfd_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  adfd_pkg::t_q_entry i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output adfd_pkg::t_q_entry o_data
);

    adfd_pkg::t_q_entry            r_mem [adfd_pkg::Q_DEPTH];
    logic [adfd_pkg::Q_PTR_W-1:0]  r_wr, r_rd;
    logic [adfd_pkg::Q_PTR_W:0]    r_count;
    logic                          do_push, do_pop;

    assign o_full  = (r_count == (adfd_pkg::Q_PTR_W+1)'(adfd_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/core/adfd_back.sv
// Unpacker: bit reservoir, one 14-bit sample per cycle when not stalled, header pass-through, output register.
module adfd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  adfd_pkg::t_q_entry i_q_data,
    output logic               o_pop,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output adfd_pkg::t_result  o_result
);

    logic [adfd_pkg::RES_W-1:0]  r_res, n_res;
    logic [adfd_pkg::FILL_W-1:0] r_fill, n_fill;
    logic [adfd_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [adfd_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                        r_act, n_act;
    adfd_pkg::t_q_entry          r_meta, n_meta;
    logic                        r_ovalid, n_ovalid;
    adfd_pkg::t_result           r_out, n_out;

    logic                        can_out, is_hdr, hdr_step, step, cond, more, drop;
    logic [adfd_pkg::RES_W-1:0]  base_res, ld_res, cur_res;
    logic [adfd_pkg::FILL_W-1:0] base_fill, ld_fill, cur_fill, nx_fill;
    logic [adfd_pkg::IDX_W-1:0]  ld_idx, cur_idx, nx_idx;
    logic [adfd_pkg::CNT_W-1:0]  cur_cnt, nx_cnt;
    adfd_pkg::t_q_entry          cur_meta;
    logic [adfd_pkg::CHAN_W:0]   chan;

    assign can_out  = !r_ovalid || i_out_ready;
    assign is_hdr   = (i_q_data.kind == adfd_pkg::KIND_HDR);
    assign o_pop    = can_out && !r_act && i_q_valid;
    assign hdr_step = o_pop && is_hdr;
    assign step     = can_out && (r_act || (i_q_valid && !is_hdr));

    // load a new data word into the reservoir
    assign drop      = i_q_data.first || (r_fill > adfd_pkg::FILL_W'(adfd_pkg::WORD_W));
    assign base_res  = drop ? '0 : r_res;
    assign base_fill = drop ? '0 : r_fill;
    assign ld_res    = base_res | (adfd_pkg::RES_W'(i_q_data.word) << base_fill);
    assign ld_fill   = base_fill + adfd_pkg::FILL_W'(adfd_pkg::WORD_W);
    assign ld_idx    = i_q_data.first ? '0 : r_idx;

    assign cur_res  = r_act ? r_res  : ld_res;
    assign cur_fill = r_act ? r_fill : ld_fill;
    assign cur_idx  = r_act ? r_idx  : ld_idx;
    assign cur_cnt  = r_act ? r_cnt  : '0;
    assign cur_meta = r_act ? r_meta : i_q_data;

    assign cond = (cur_fill >= adfd_pkg::FILL_W'(adfd_pkg::SAMPLE_BITS))
               && (cur_idx < adfd_pkg::IDX_W'(adfd_pkg::SPB))
               && (cur_cnt < adfd_pkg::CNT_W'(adfd_pkg::MAX_OUT));
    assign nx_fill = cur_fill - adfd_pkg::FILL_W'(adfd_pkg::SAMPLE_BITS);
    assign nx_idx  = cur_idx + 1'b1;
    assign nx_cnt  = cur_cnt + 1'b1;
    assign more = cond
               && (nx_fill >= adfd_pkg::FILL_W'(adfd_pkg::SAMPLE_BITS))
               && (nx_idx < adfd_pkg::IDX_W'(adfd_pkg::SPB))
               && (nx_cnt < adfd_pkg::CNT_W'(adfd_pkg::MAX_OUT));

    assign chan = (cur_meta.blk ? (adfd_pkg::CHAN_W+1)'(adfd_pkg::SPB) : '0)
               + (adfd_pkg::CHAN_W+1)'(cur_idx);

    always_comb begin
        n_res    = r_res;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_act    = r_act;
        n_meta   = r_meta;
        n_ovalid = r_ovalid;
        n_out    = r_out;

        if (can_out) begin
            n_ovalid = 1'b0;
        end

        if (step) begin
            n_meta = cur_meta;
            if (cond) begin
                n_res  = cur_res >> adfd_pkg::SAMPLE_BITS;
                n_fill = nx_fill;
                n_idx  = nx_idx;
                n_cnt  = nx_cnt;
                n_act  = more;
                n_ovalid        = 1'b1;
                n_out.kind      = adfd_pkg::KIND_SAMPLE;
                n_out.channel   = chan[adfd_pkg::CHAN_W-1:0];
                n_out.sample    = cur_res[adfd_pkg::SAMPLE_BITS-1:0];
                n_out.tick      = cur_meta.tick;
                n_out.timestamp = '0;
                n_out.slot      = cur_meta.slot;
                n_out.fiber     = cur_meta.fiber;
                n_out.status    = cur_meta.status;
                n_out.last      = !more;
                if (!more && (nx_idx >= adfd_pkg::IDX_W'(adfd_pkg::SPB))) begin
                    n_res  = '0;
                    n_fill = '0;
                end
            end else begin
                // word yields no sample: keep the loaded reservoir, or clear it past the block end
                n_res  = cur_res;
                n_fill = cur_fill;
                n_idx  = cur_idx;
                n_act  = 1'b0;
                if (cur_idx >= adfd_pkg::IDX_W'(adfd_pkg::SPB)) begin
                    n_res  = '0;
                    n_fill = '0;
                end
            end
        end else if (hdr_step) begin
            n_ovalid        = 1'b1;
            n_out.kind      = adfd_pkg::KIND_HDR;
            n_out.channel   = '0;
            n_out.sample    = '0;
            n_out.tick      = i_q_data.tick;
            n_out.timestamp = {i_q_data.word, i_q_data.ts_low};
            n_out.slot      = i_q_data.slot;
            n_out.fiber     = i_q_data.fiber;
            n_out.status    = i_q_data.status;
            n_out.last      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res    <= '0;
            r_fill   <= '0;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_act    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_res    <= n_res;
            r_fill   <= n_fill;
            r_idx    <= n_idx;
            r_cnt    <= n_cnt;
            r_act    <= n_act;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_meta <= n_meta;
        r_out  <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_result    = r_out;

endmodule

FILE: rtl/core/adc_frame_deframer_unpack14.sv
// Top level of the packed 14-bit sample frame deframer.
//
// Input channel i_in carries one 32-bit frame word per handshake; frames are
// 117 words. Word 0 gives slot (bits 14:12) and fiber (bit 15), words 2/3 the
// 64-bit timestamp, words 4..59 and 60..115 two blocks of 128 packed samples.
// Output channel o_out carries result words: one header word at frame word 3,
// and one sample word per completed 14-bit sample (channel 0..255); last marks
// the final result of an input word. i_cfg_we/i_cfg_data write the frames per
// readout setting (reset 2000), which sets where tick wraps and slot/fiber
// relatch; write it only while the block is idle.
// An accepted word is queued, then the unpacker registers its first result
// word. The front end takes a word per cycle into a 4-entry queue while it
// has room; the unpacker spends one cycle per result word when the output
// does not stall, so it sets the sustained rate. Words that give no result
// never enter the queue. Reset (synchronous, active low) returns to frame
// word 0, tick 0, empty queue. When the receiver stalls, the output register
// holds its word, the unpacker stops, and the front end keeps taking words
// until the queue fills.
module adc_frame_deframer_unpack14 (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    adfd_in_if.sink                     i_in,
    adfd_out_if.source                  o_out,
    input  logic                        i_cfg_we,
    input  logic [adfd_pkg::TICK_W-1:0] i_cfg_data
);

    logic [adfd_pkg::TICK_W-1:0] r_fpr;
    logic                        q_full, q_push, q_pop, q_valid;
    adfd_pkg::t_q_entry          q_in, q_out;
    adfd_pkg::t_result           res;

    // frames per readout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fpr <= adfd_pkg::FPR_RESET;
        end else if (i_cfg_we) begin
            r_fpr <= i_cfg_data;
        end
    end

    adfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .i_word   (i_in.frame_word),
        .o_ready  (i_in.ready),
        .i_fpr    (r_fpr),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_entry  (q_in)
    );

    adfd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    adfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_out),
        .o_pop       (q_pop),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_result    (res)
    );

    assign o_out.kind      = res.kind;
    assign o_out.channel   = res.channel;
    assign o_out.sample    = res.sample;
    assign o_out.tick      = res.tick;
    assign o_out.timestamp = res.timestamp;
    assign o_out.slot      = res.slot;
    assign o_out.fiber     = res.fiber;
    assign o_out.status    = res.status;
    assign o_out.last      = res.last;

endmodule

FILE: rtl/core/adfd_checker.sv
// Port-level checks on the deframer output channel, bound to the top level.
module adfd_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             i_ready,
    input  logic                             i_kind,
    input  logic [adfd_pkg::CHAN_W-1:0]      i_channel,
    input  logic [adfd_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [adfd_pkg::TS_W-1:0]        i_timestamp,
    input  logic [1:0]                       i_status,
    input  logic                             i_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_sample)
            && $stable(i_channel) && $stable(i_timestamp) && $stable(i_last))
        else $error("stalled result word changed");

    a_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == adfd_pkg::KIND_HDR)
            |-> i_last && (i_channel == '0) && (i_sample == '0))
        else $error("header word malformed");

    a_smp_ts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == adfd_pkg::KIND_SAMPLE) |-> (i_timestamp == '0))
        else $error("sample word carries a timestamp");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_status == adfd_pkg::ST_OK) || (i_status == adfd_pkg::ST_SLOT)
            || (i_status == adfd_pkg::ST_FIBER))
        else $error("bad status code");

endmodule

bind adc_frame_deframer_unpack14 adfd_checker u_adfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_out.valid),
    .i_ready     (o_out.ready),
    .i_kind      (o_out.kind),
    .i_channel   (o_out.channel),
    .i_sample    (o_out.sample),
    .i_timestamp (o_out.timestamp),
    .i_status    (o_out.status),
    .i_last      (o_out.last)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the packed 14-bit sample frame deframer.
module tb_top;
    import adfd_pkg::*;

    // Run limit: the slowest correct run (about 160 words, up to 3 result
    // words each, random stalls on both sides, one long hold-off) stays
    // under this limit.
    localparam int LIMIT_NS  = 2_000_000;
    localparam int HOLD_LEN  = 250;    // long receiver hold-off, in cycles
    localparam int HOLD_AT   = 30;     // words accepted before it starts
    localparam int SETTLE    = 16;     // cycles after the last result word
    localparam int MAX_SHOWN = 10;
    localparam int TAIL_AT   = 24;     // frame 1 words sent before idling stops
    localparam int LAST_POS  = 43;     // frame 1 is cut short here

    // how the data words of a queued frame are filled
    typedef enum int {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS
    } t_fill;

    // how word 0 of a queued frame relates to the latched slot/fiber
    typedef enum int {
        W0_MATCH,
        W0_SLOT,
        W0_FIBER,
        W0_ANY
    } t_hdr;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [TICK_W-1:0] cfg_data;

    adfd_in_if  in_if ();
    adfd_out_if out_if ();

    adc_frame_deframer_unpack14 DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Deframer state as the block should hold it
    // ------------------------------------------------------------------
    int                     fr_pos;       // word position within the frame
    logic [TICK_W-1:0]      fr_tick;      // frame number within the readout
    logic [TICK_W-1:0]      fr_len;       // frames per readout setting
    logic [63:0]            bits_acc;     // packed sample bit reservoir
    int                     bits_fill;
    int                     smp_idx;
    logic [WORD_W-1:0]      ts_lo;
    logic [SLOT_W-1:0]      lat_slot;
    logic                   lat_fiber;
    logic [SLOT_W-1:0]      cur_slot;
    logic                   cur_fiber;
    t_status                cur_status;

    t_result                unpacked_q[$];   // result words still to arrive
    logic [WORD_W-1:0]      frame_stream[$]; // words not yet offered

    // stimulus-side view of tick and latch, used only to shape word 0
    logic [TICK_W-1:0]      gen_tick;
    logic [SLOT_W-1:0]      gen_slot;
    logic                   gen_fiber;

    int   n_words, n_results, n_headers, n_frames, n_fail;
    logic idle_on;
    logic in_vld;
    logic word_taken;
    int   in_gap, out_gap, hold_left;
    logic hold_used, hold_active, rdy;
    t_result oldest;
    t_result got;

    function automatic t_result result_word(t_kind k, logic [CHAN_W-1:0] chan,
                                            logic [SAMPLE_BITS-1:0] smp,
                                            logic [TS_W-1:0] ts);
        t_result r;
        r.kind      = k;
        r.channel   = chan;
        r.sample    = smp;
        r.tick      = fr_tick;
        r.timestamp = ts;
        r.slot      = cur_slot;
        r.fiber     = cur_fiber;
        r.status    = cur_status;
        r.last      = 1'b0;
        return r;
    endfunction

    function automatic void show_word(input string tag, input t_result r);
        $display("%s kind %0b ch %0d smp %h tick %0d ts %h sl %0d fb %0b st %0d last %0b",
                 tag, r.kind, r.channel, r.sample, r.tick, r.timestamp, r.slot,
                 r.fiber, r.status, r.last);
    endfunction

    // Advance the deframer by one accepted word and queue the result words.
    task automatic unpack_word(input logic [WORD_W-1:0] w);
        t_result r [MAX_OUT];
        int n, off, blk, wib, k;
        n = 0;
        if (fr_pos == 0) begin
            cur_slot  = w[SLOT_LSB +: SLOT_W];
            cur_fiber = w[FIBER_BIT];
            // first frame of a readout relatches and is always ok
            if (fr_tick == '0) begin
                lat_slot   = cur_slot;
                lat_fiber  = cur_fiber;
                cur_status = ST_OK;
            end else if (cur_slot != lat_slot) begin
                cur_status = ST_SLOT;     // slot wins when both differ
            end else if (cur_fiber != lat_fiber) begin
                cur_status = ST_FIBER;
            end else begin
                cur_status = ST_OK;
            end
        end else if (fr_pos == TS_LOW) begin
            ts_lo = w;
        end else if (fr_pos == TS_HIGH) begin
            r[0] = result_word(KIND_HDR, '0, '0, {w, ts_lo});
            n = 1;
        end else if (fr_pos >= DATA_START && fr_pos < DATA_END) begin
            off = fr_pos - DATA_START;
            blk = (off >= BLOCK_WORDS) ? 1 : 0;
            wib = blk ? off - BLOCK_WORDS : off;
            if (wib == 0 || bits_fill > 32) begin
                bits_acc  = '0;
                bits_fill = 0;
                if (wib == 0)
                    smp_idx = 0;
            end
            bits_acc  = bits_acc | (64'(w) << bits_fill);
            bits_fill = bits_fill + WORD_W;
            while (bits_fill >= SAMPLE_BITS && smp_idx < SPB && n < MAX_OUT) begin
                r[n] = result_word(KIND_SAMPLE, CHAN_W'(blk * SPB + smp_idx),
                                   bits_acc[SAMPLE_BITS-1:0], '0);
                bits_acc  = bits_acc >> SAMPLE_BITS;
                bits_fill = bits_fill - SAMPLE_BITS;
                smp_idx++;
                n++;
            end
            // bits past the last sample of a block are dropped
            if (smp_idx >= SPB) begin
                bits_acc  = '0;
                bits_fill = 0;
            end
        end
        for (k = 0; k < n; k++) begin
            if (k == n - 1)
                r[k].last = 1'b1;
            unpacked_q = {unpacked_q, r[k]};
        end
        if (fr_pos + 1 >= FRAME_WORDS) begin
            fr_pos = 0;
            // a setting of 0 acts as 1: every frame relatches
            if (int'(fr_tick) + 1 >= int'(fr_len))
                fr_tick = '0;
            else
                fr_tick = fr_tick + 1'b1;
        end else begin
            fr_pos++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                unpack_word(in_if.frame_word);
                n_words++;
                word_taken = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                got.kind      = t_kind'(out_if.kind);
                got.channel   = out_if.channel;
                got.sample    = out_if.sample;
                got.tick      = out_if.tick;
                got.timestamp = out_if.timestamp;
                got.slot      = out_if.slot;
                got.fiber     = out_if.fiber;
                got.status    = t_status'(out_if.status);
                got.last      = out_if.last;
                if (unpacked_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= MAX_SHOWN)
                        show_word("tb: result word with none due:", got);
                end else begin
                    oldest = unpacked_q.pop_front();
                    n_results++;
                    if (oldest.kind == KIND_HDR)
                        n_headers++;
                    if (got !== oldest) begin
                        n_fail++;
                        if (n_fail <= MAX_SHOWN) begin
                            show_word("tb: mismatch exp", oldest);
                            show_word("tb:          got", got);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offer frame words at the falling edge, with idle bursts
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (word_taken) begin
            word_taken = 1'b0;
            in_vld     = 1'b0;
        end
        if (!in_vld && i_rst_n) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (frame_stream.size() > 0) begin
                if (idle_on && $urandom_range(0, 5) == 0) begin
                    in_gap = $urandom_range(1, 9) - 1;
                end else begin
                    in_if.frame_word <= frame_stream.pop_front();
                    in_vld = 1'b1;
                end
            end
        end
        in_if.valid <= in_vld;
    end

    // Receiver: random stall bursts, plus the long hold-off below
    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            out_gap--;
            rdy = 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            out_gap = $urandom_range(1, 9) - 1;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        out_if.ready <= rdy && !hold_active;
    end

    // One long hold-off early in the run; the sender keeps offering words so
    // the internal queue fills and the block has to drop ready on its input.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
        end else if (!hold_used && n_words >= HOLD_AT) begin
            hold_left = HOLD_LEN;
            hold_used = 1'b1;
        end
        hold_active <= (hold_left > 0);
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [WORD_W-1:0] fill_word(t_fill fill, int wib, int blk);
        if (fill == FILL_ONES && wib < 4)
            return '1;
        if (fill == FILL_ONES && wib < 8)
            return '0;
        if (fill == FILL_ZEROS && wib < 4)
            return '0;
        if (fill == FILL_ZEROS && wib < 8)
            return blk ? 32'h5555_5555 : 32'hAAAA_AAAA;
        return $urandom;
    endfunction

    // Queue frame words from position first_pos up to (not including) end_pos;
    // word 0 is steered against the latched slot/fiber.
    task automatic queue_frame(input t_fill fill, input t_hdr mode,
                               input int first_pos, input int end_pos);
        logic [WORD_W-1:0] w;
        logic [SLOT_W-1:0] s;
        logic              f;
        int                pos, off;
        for (pos = first_pos; pos < end_pos; pos++) begin
            off = pos - DATA_START;
            if (pos == 0) begin
                w = (fill == FILL_ONES) ? '1 : (fill == FILL_ZEROS) ? '0 : $urandom;
                if (gen_tick == '0 || mode == W0_ANY) begin
                    s = (fill == FILL_ONES) ? '1 : SLOT_W'($urandom);
                    f = (fill == FILL_ONES) ? 1'b1 : 1'($urandom);
                end else if (mode == W0_MATCH) begin
                    s = gen_slot;
                    f = gen_fiber;
                end else if (mode == W0_SLOT) begin
                    s = gen_slot ^ SLOT_W'($urandom_range(1, 7));
                    f = 1'($urandom);
                end else begin
                    s = gen_slot;
                    f = ~gen_fiber;
                end
                w[SLOT_LSB +: SLOT_W] = s;
                w[FIBER_BIT]          = f;
                if (gen_tick == '0) begin
                    gen_slot  = s;
                    gen_fiber = f;
                end
                n_frames++;
            end else if (pos < DATA_START) begin
                w = (fill == FILL_ONES) ? '1 : (fill == FILL_ZEROS) ? '0 : $urandom;
            end else if (pos < DATA_END) begin
                w = fill_word(fill, off % BLOCK_WORDS, off / BLOCK_WORDS);
            end else begin
                w = $urandom;
            end
            frame_stream = {frame_stream, w};
        end
        if (end_pos >= FRAME_WORDS) begin
            if (int'(gen_tick) + 1 >= int'(fr_len))
                gen_tick = '0;
            else
                gen_tick = gen_tick + 1'b1;
        end
    endtask

    // Wait until every word is taken and every result word has arrived,
    // then let the tail of the pipeline settle (frame tail words give none).
    task automatic drain();
        while (frame_stream.size() != 0 || in_vld || unpacked_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        gen_tick  = fr_tick;
        gen_slot  = lat_slot;
        gen_fiber = lat_fiber;
    endtask

    task automatic set_readout_len(input logic [TICK_W-1:0] v);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        fr_len = v;
        gen_tick = fr_tick;
    endtask

    initial begin
        in_if.valid      = 1'b0;
        in_if.frame_word = '0;
        out_if.ready     = 1'b0;
        cfg_we           = 1'b0;
        cfg_data         = '0;
        i_rst_n          = 1'b0;
        fr_pos = 0;  fr_tick = '0;  fr_len = FPR_RESET;
        bits_acc = '0;  bits_fill = 0;  smp_idx = 0;  ts_lo = '0;
        lat_slot = '0;  lat_fiber = 1'b0;
        cur_slot = '0;  cur_fiber = 1'b0;  cur_status = ST_OK;
        gen_tick = '0;  gen_slot = '0;  gen_fiber = 1'b0;
        n_words = 0;  n_results = 0;  n_headers = 0;  n_frames = 0;  n_fail = 0;
        idle_on = 1'b1;  in_vld = 1'b0;  word_taken = 1'b0;
        in_gap = 0;  out_gap = 0;  hold_left = 0;
        hold_used = 1'b0;  hold_active = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: one whole frame of extremes that latches slot/fiber,
        // both block boundaries and the ignored tail word.
        queue_frame(FILL_ONES, W0_ANY, 0, FRAME_WORDS);
        drain();

        // Setting write at a frame boundary, then a slot mismatch frame.
        set_readout_len(16'd2);
        queue_frame(FILL_ZEROS, W0_SLOT, 0, TAIL_AT);
        drain();

        // Rest of the run with no idling on either side.
        idle_on = 1'b0;
        queue_frame(FILL_ZEROS, W0_SLOT, TAIL_AT, LAST_POS);
        drain();

        if (unpacked_q.size() != 0)
            n_fail++;
        $display("tb: %0d words in %0d frames, %0d result words checked (%0d headers)",
                 n_words, n_frames, n_results, n_headers);
        $display("tb: latch frame under a long output hold-off, setting write, slot mismatch");
        if (n_fail == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/adfd_pkg.sv
rtl/core/adfd_ifs.sv
rtl/core/adfd_front.sv
rtl/core/adfd_fifo.sv
rtl/core/adfd_back.sv
rtl/core/adc_frame_deframer_unpack14.sv
rtl/core/adfd_checker.sv
tb/tb_top.sv
